// ===== design/tso_pkg.sv =====
// Package for the table shaped oscillator: payload types, register codes and breakpoint ROMs.
package tso_pkg;

  // Request payloads
  typedef struct packed {
    logic [21:0] frequency_q8;
  } in_payload_t;

  typedef struct packed {
    logic signed [15:0] wave_sample;
    logic               last_of_run;
  } out_payload_t;

  // Configuration port
  localparam int unsigned CFG_AW = 4;
  localparam logic [1:0] REG_INCREMENT  = 2'd0;
  localparam logic [1:0] REG_BLEND_LOW  = 2'd1;
  localparam logic [1:0] REG_BLEND_HIGH = 2'd2;

  localparam logic [31:0] INCREMENT_RESET  = 32'd5726623;
  localparam logic [9:0]  BLEND_LOW_RESET  = 10'd20;
  localparam logic [10:0] BLEND_HIGH_RESET = 11'd100;

  // Breakpoint table geometry
  localparam int unsigned LOW_POINTS  = 38;
  localparam int unsigned HIGH_POINTS = 24;
  localparam int unsigned TAB_SLOTS   = 64;
  localparam int unsigned TAB_IW      = 6;
  localparam int unsigned PHX_W       = 25;  // position 1.0 maps to 2^24
  localparam int unsigned VAL_W       = 18;
  localparam int unsigned DEN_W       = 38;  // 1e5 times widest segment
  localparam longint      DEC_UNIT    = 100000;

  // Shared divider: 22 quotient bits, 60-bit dividend
  localparam int unsigned DIV_STEPS = 22;
  localparam int unsigned DIV_NW    = 60;
  localparam int unsigned DIV_CW    = 5;

  typedef logic [TAB_SLOTS-1:0][PHX_W-1:0] phx_tab_t;
  typedef logic [TAB_SLOTS-1:0][VAL_W-1:0] val_tab_t;
  typedef logic [TAB_SLOTS-1:0][DEN_W-1:0] den_tab_t;

  // Breakpoints in units of 1e-5 wave period and 1e-5 full scale
  localparam int LOW_POS [LOW_POINTS] = '{
    0, 1900, 4038, 6176, 9026, 11876, 14727, 20428, 23753, 26603,
    29454, 32779, 36342, 40380, 44181, 48931, 54157, 56532, 57482, 58432,
    59857, 61283, 62233, 63895, 66033, 68646, 70784, 72684, 74584, 76485,
    79810, 84561, 88836, 92637, 95012, 96437, 97387, 100000
  };
  localparam int LOW_VAL [LOW_POINTS] = '{
    -97516, -62733, -32919, -5590, 16770, 31677, 37888, 37888, 39130, 39130,
    34161, 27329, 18012, 8075, 1863, -3106, -6832, -8075, -5590, 98758,
    72671, 47826, 25466, 1863, -20497, -34161, -39130, -40994, -40373, -37888,
    -30435, -20497, -13665, -7453, -4348, -4348, -11801, -100000
  };
  localparam int HIGH_POS [HIGH_POINTS] = '{
    0, 4369, 7217, 12291, 18122, 25493, 29199, 34421, 39654, 40892,
    42182, 43633, 48239, 52886, 56024, 59896, 63756, 69872, 72920, 75975,
    80528, 85818, 91102, 100000
  };
  localparam int HIGH_VAL [HIGH_POINTS] = '{
    -100787, -81890, -60630, -35433, -11024, 8661, 15748, 21260, 25197, 60630,
    88976, 96063, 83465, 65354, 48031, 33071, 19685, 6299, 787, -5512,
    -11024, -14567, -17323, -100787
  };

  // Round half up from 1e-5 wave period to 2^-24 wave period
  function automatic longint to_phase(input longint x);
    return (x * 64'sd16777216 + DEC_UNIT / 2) / DEC_UNIT;
  endfunction

  function automatic longint pos_of(input logic sel, input int k);
    return sel ? longint'(HIGH_POS[k]) : longint'(LOW_POS[k]);
  endfunction

  function automatic int points_of(input logic sel);
    return sel ? int'(HIGH_POINTS) : int'(LOW_POINTS);
  endfunction

  // Unused slots sit above any phase so the search never passes them
  function automatic phx_tab_t build_phx(input logic sel);
    phx_tab_t tab;
    int       k;
    tab = '1;
    for (k = 0; k < points_of(sel); k++) begin
      tab[k] = PHX_W'(to_phase(pos_of(sel, k)));
    end
    return tab;
  endfunction

  function automatic val_tab_t build_val(input logic sel);
    val_tab_t tab;
    int       k;
    tab = '0;
    for (k = 0; k < points_of(sel); k++) begin
      tab[k] = sel ? VAL_W'(HIGH_VAL[k]) : VAL_W'(LOW_VAL[k]);
    end
    return tab;
  endfunction

  // Divisor of each segment: 1e5 times its width in phase units
  function automatic den_tab_t build_den(input logic sel);
    den_tab_t tab;
    int       k;
    tab = '0;
    for (k = 0; k < points_of(sel) - 1; k++) begin
      tab[k] = DEN_W'(DEC_UNIT * (to_phase(pos_of(sel, k + 1)) - to_phase(pos_of(sel, k))));
    end
    return tab;
  endfunction

  localparam phx_tab_t PHX_LOW  = build_phx(1'b0);
  localparam phx_tab_t PHX_HIGH = build_phx(1'b1);
  localparam val_tab_t VAL_LOW  = build_val(1'b0);
  localparam val_tab_t VAL_HIGH = build_val(1'b1);
  localparam den_tab_t DEN_LOW  = build_den(1'b0);
  localparam den_tab_t DEN_HIGH = build_den(1'b1);

  // ROM reads, sel high picks the high table
  function automatic logic [PHX_W-1:0] phx_at(input logic sel, input logic [TAB_IW-1:0] k);
    return sel ? PHX_HIGH[k] : PHX_LOW[k];
  endfunction

  function automatic logic signed [VAL_W-1:0] val_at(input logic sel,
                                                      input logic [TAB_IW-1:0] k);
    return sel ? $signed(VAL_HIGH[k]) : $signed(VAL_LOW[k]);
  endfunction

  function automatic logic [DEN_W-1:0] den_at(input logic sel, input logic [TAB_IW-1:0] k);
    return sel ? DEN_HIGH[k] : DEN_LOW[k];
  endfunction

  function automatic logic [TAB_IW-1:0] last_idx(input logic sel);
    return sel ? TAB_IW'(HIGH_POINTS - 1) : TAB_IW'(LOW_POINTS - 1);
  endfunction

endpackage

// ===== design/tso_stream_if.sv =====
// Valid/ready stream channel carrying one request payload.
interface tso_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/table_shaped_oscillator.sv =====
// Table shaped oscillator: oversampled two-table piecewise linear wave with frequency crossfade.
// A request is taken only in idle; its OVERSAMPLE_FACTOR samples are then computed and offered one by one,
//   and no new request is taken until the last of them has been loaded into the output register.
// Each sample runs the 22-step shared divider once per table and once more for the crossfade;
// with blend_high_hz <= blend_low_hz the crossfade division is skipped.
// Reset (async, active low) clears the phase, the sequencer and the output valid, and loads the registers.
module table_shaped_oscillator
  import tso_pkg::*;
#(
  parameter int unsigned OVERSAMPLE_FACTOR = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  tso_stream_if.sink        in_i,
  tso_stream_if.source      out_o
);

  localparam int unsigned SAMP_W = (OVERSAMPLE_FACTOR > 1) ? $clog2(OVERSAMPLE_FACTOR) : 1;

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b0000_0000_0001,
    ST_DELTA = 12'b0000_0000_0010,
    ST_STEP  = 12'b0000_0000_0100,
    ST_SRCH  = 12'b0000_0000_1000,
    ST_SEG   = 12'b0000_0001_0000,
    ST_MUL0  = 12'b0000_0010_0000,
    ST_MUL1  = 12'b0000_0100_0000,
    ST_DIVLD = 12'b0000_1000_0000,
    ST_DIV   = 12'b0001_0000_0000,
    ST_DFIN  = 12'b0010_0000_0000,
    ST_MULB  = 12'b0100_0000_0000,
    ST_SEND  = 12'b1000_0000_0000
  } state_e;

  typedef enum logic [1:0] {
    JOB_LOW,
    JOB_HIGH,
    JOB_BLEND
  } job_e;

  // Control state
  state_e              state_q, state_d;
  job_e                job_q, job_d;
  logic [TAB_IW-1:0]   idx_q, idx_d;
  logic [2:0]          bit_q, bit_d;
  logic [DIV_CW-1:0]   cnt_q, cnt_d;
  logic [SAMP_W-1:0]   samp_q, samp_d;
  logic [23:0]         phase_q, phase_d;
  logic                out_valid_q, out_valid_d;
  logic [31:0]         inc_q;
  logic [9:0]          blend_lo_q;
  logic [10:0]         blend_hi_q;

  // Datapath registers
  logic [21:0]         f_q;
  logic [23:0]         delta_q;
  logic                ordered_q, pick_low_q;
  logic [18:0]         fcl_q, bden_q;
  logic signed [17:0]  va_q;
  logic [21:0]         dx_q, t_q;
  logic signed [18:0]  dy_q;
  logic [DEN_W-1:0]    den_q;
  logic signed [56:0]  prod_q;
  logic signed [39:0]  acc_q;
  logic [DEN_W-1:0]    rem_q;
  logic [DIV_STEPS-1:0] quo_q;
  logic                div_neg_q;
  logic signed [22:0]  lv_q, hv_q;
  logic signed [23:0]  v_q;
  out_payload_t        out_data_q;

  logic in_fire, out_load, samp_last, tbl;
  assign tbl       = (job_q == JOB_HIGH);
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire   = in_i.valid && in_i.ready;
  assign out_load  = (state_q == ST_SEND) && (!out_valid_q || out_o.ready);
  assign samp_last = (samp_q == SAMP_W'(OVERSAMPLE_FACTOR - 1));
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // Configuration port
  logic cfg_we;
  assign cfg_we = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      REG_INCREMENT:  prdata = inc_q;
      REG_BLEND_LOW:  prdata = {22'b0, blend_lo_q};
      REG_BLEND_HIGH: prdata = {21'b0, blend_hi_q};
      default:        prdata = '0;
    endcase
  end

  // Shared multiplier, operands picked by the sequencer
  logic signed [32:0] mul_a;
  logic signed [23:0] mul_b;
  logic signed [56:0] prod_d;
  logic signed [23:0] dv;

  assign dv = {hv_q[22], hv_q} - {lv_q[22], lv_q};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_IDLE: begin
        mul_a = {1'b0, inc_q};
        mul_b = {2'b0, in_i.data.frequency_q8};
      end
      ST_MUL0: begin
        mul_a = {{15{va_q[17]}}, va_q};
        mul_b = {2'b0, dx_q};
      end
      ST_MUL1: begin
        mul_a = {{14{dy_q[18]}}, dy_q};
        mul_b = {2'b0, t_q};
      end
      ST_MULB: begin
        mul_a = {{9{dv[23]}}, dv};
        mul_b = {5'b0, fcl_q};
      end
      default: ;
    endcase
  end
  assign prod_d = mul_a * mul_b;

  // Corner frequencies in Q8
  logic [21:0] lo22, hi22, fc22, fcl22, bden22;
  assign lo22   = {4'b0, blend_lo_q, 8'b0};
  assign hi22   = {3'b0, blend_hi_q, 8'b0};
  assign fc22   = (f_q < lo22) ? lo22 : ((f_q > hi22) ? hi22 : f_q);
  assign fcl22  = fc22 - lo22;
  assign bden22 = hi22 - lo22;

  // Binary search step: count breakpoints strictly below the phase
  logic [TAB_IW-1:0] srch_cand;
  logic              srch_lt;
  assign srch_cand = idx_q + (TAB_IW'(1) << bit_q);
  assign srch_lt   = phx_at(tbl, srch_cand - TAB_IW'(1)) < {1'b0, phase_q};

  // Segment setup from the search result
  logic [TAB_IW-1:0]        seg_i, seg_n, seg_last;
  logic [PHX_W-1:0]         p25, xl, xr, dx25, t25;
  logic                     over, under, flat;
  logic signed [VAL_W-1:0]  v0, v1, vend;
  logic signed [18:0]       dy_w;

  assign p25      = {1'b0, phase_q};
  assign seg_i    = (idx_q == '0) ? '0 : idx_q - TAB_IW'(1);
  assign seg_n    = seg_i + TAB_IW'(1);
  assign seg_last = last_idx(tbl);
  assign xl       = phx_at(tbl, seg_i);
  assign xr       = phx_at(tbl, seg_n);
  assign dx25     = xr - xl;
  assign t25      = p25 - xl;
  assign over     = p25 > phx_at(tbl, seg_last);
  assign under    = p25 < phx_at(tbl, '0);
  assign flat     = over || under || (dx25 == '0);
  assign v0       = val_at(tbl, seg_i);
  assign v1       = val_at(tbl, seg_n);
  assign vend     = over ? val_at(tbl, seg_last) : (under ? val_at(tbl, '0) : v0);
  assign dy_w     = {v1[17], v1} - {v0[17], v0};

  // Divider load: magnitude and sign of the dividend
  logic signed [39:0]  tsum;
  logic [39:0]         tabs;
  logic [42:0]         babs;
  logic [DIV_NW-1:0]   nmag;
  logic                nneg;

  assign tsum = acc_q + prod_q[39:0];
  assign tabs = tsum[39] ? 40'(-tsum) : 40'(tsum);
  assign babs = prod_q[42] ? 43'(-prod_q[42:0]) : prod_q[42:0];
  assign nneg = (job_q == JOB_BLEND) ? prod_q[56] : tsum[39];
  assign nmag = (job_q == JOB_BLEND) ? {17'b0, babs} : {tabs, 20'b0};

  // Divider step and floored signed result
  logic [DEN_W:0]      trial;
  logic                trial_ge;
  logic [23:0]         qs;
  logic signed [23:0]  res;

  assign trial    = {rem_q, quo_q[DIV_STEPS-1]};
  assign trial_ge = trial >= {1'b0, den_q};
  assign qs       = {2'b0, quo_q} + {23'b0, div_neg_q && (rem_q != '0)};
  assign res      = div_neg_q ? -$signed(qs) : $signed(qs);

  // Output rounding to Q2.14 with saturation
  logic signed [23:0] vr;
  logic signed [17:0] sh;
  logic signed [15:0] smp;
  assign vr = v_q + 24'sd32;
  assign sh = vr[23:6];
  always_comb begin
    if (sh > 18'sd32767) begin
      smp = 16'sh7FFF;
    end else if (sh < -18'sd32768) begin
      smp = 16'sh8000;
    end else begin
      smp = sh[15:0];
    end
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    job_d       = job_q;
    idx_d       = idx_q;
    bit_d       = bit_q;
    cnt_d       = cnt_q;
    samp_d      = samp_q;
    phase_d     = phase_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) state_d = ST_DELTA;
      end
      ST_DELTA: begin
        samp_d  = '0;
        state_d = ST_STEP;
      end
      ST_STEP: begin
        phase_d = phase_q + delta_q;
        job_d   = JOB_LOW;
        idx_d   = '0;
        bit_d   = 3'(TAB_IW - 1);
        state_d = ST_SRCH;
      end
      ST_SRCH: begin
        if (srch_lt) idx_d = srch_cand;
        if (bit_q == '0) begin
          state_d = ST_SEG;
        end else begin
          bit_d = bit_q - 3'd1;
        end
      end
      ST_SEG:   state_d = ST_MUL0;
      ST_MUL0:  state_d = ST_MUL1;
      ST_MUL1:  state_d = ST_DIVLD;
      ST_DIVLD: begin
        cnt_d   = DIV_CW'(DIV_STEPS - 1);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cnt_d = cnt_q - DIV_CW'(1);
        if (cnt_q == '0) state_d = ST_DFIN;
      end
      ST_DFIN: begin
        case (job_q)
          JOB_LOW: begin
            job_d   = JOB_HIGH;
            idx_d   = '0;
            bit_d   = 3'(TAB_IW - 1);
            state_d = ST_SRCH;
          end
          JOB_HIGH: begin
            if (ordered_q) begin
              job_d   = JOB_BLEND;
              state_d = ST_MULB;
            end else begin
              state_d = ST_SEND;
            end
          end
          default: state_d = ST_SEND;
        endcase
      end
      ST_MULB:  state_d = ST_DIVLD;
      ST_SEND: begin
        if (out_load) begin
          if (samp_last) begin
            state_d = ST_IDLE;
          end else begin
            samp_d  = samp_q + SAMP_W'(1);
            state_d = ST_STEP;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      job_q       <= JOB_LOW;
      idx_q       <= '0;
      bit_q       <= '0;
      cnt_q       <= '0;
      samp_q      <= '0;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
      inc_q       <= INCREMENT_RESET;
      blend_lo_q  <= BLEND_LOW_RESET;
      blend_hi_q  <= BLEND_HIGH_RESET;
    end else begin
      state_q     <= state_d;
      job_q       <= job_d;
      idx_q       <= idx_d;
      bit_q       <= bit_d;
      cnt_q       <= cnt_d;
      samp_q      <= samp_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
      if (cfg_we) begin
        unique case (paddr[3:2])
          REG_INCREMENT:  inc_q      <= pwdata;
          REG_BLEND_LOW:  blend_lo_q <= pwdata[9:0];
          REG_BLEND_HIGH: blend_hi_q <= pwdata[10:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        f_q    <= in_i.data.frequency_q8;
        prod_q <= prod_d;
      end
      ST_DELTA: begin
        delta_q    <= prod_q[47:24];
        ordered_q  <= hi22 > lo22;
        pick_low_q <= f_q <= lo22;
        fcl_q      <= fcl22[18:0];
        bden_q     <= bden22[18:0];
      end
      ST_SEG: begin
        va_q  <= flat ? vend : v0;
        dx_q  <= flat ? 22'd1 : dx25[21:0];
        t_q   <= flat ? 22'd0 : t25[21:0];
        dy_q  <= flat ? 19'sd0 : dy_w;
        den_q <= flat ? DEN_W'(DEC_UNIT) : den_at(tbl, seg_i);
      end
      ST_MUL0: prod_q <= prod_d;
      ST_MUL1: begin
        acc_q  <= prod_q[39:0];
        prod_q <= prod_d;
      end
      ST_MULB: begin
        prod_q <= prod_d;
        den_q  <= {{(DEN_W - 19){1'b0}}, bden_q};
      end
      ST_DIVLD: begin
        div_neg_q <= nneg;
        rem_q     <= nmag[DIV_NW-1:DIV_STEPS];
        quo_q     <= nmag[DIV_STEPS-1:0];
      end
      ST_DIV: begin
        rem_q <= trial_ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
        quo_q <= {quo_q[DIV_STEPS-2:0], trial_ge};
      end
      ST_DFIN: begin
        case (job_q)
          JOB_LOW:  lv_q <= res[22:0];
          JOB_HIGH: begin
            hv_q <= res[22:0];
            v_q  <= pick_low_q ? {lv_q[22], lv_q} : res;
          end
          default:  v_q <= {lv_q[22], lv_q} + res;
        endcase
      end
      ST_SEND: begin
        if (out_load) begin
          out_data_q.wave_sample <= smp;
          out_data_q.last_of_run <= samp_last;
        end
      end
      default: ;
    endcase
  end

  // Remainder stays below the divisor throughout a division
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < den_q) && (den_q != '0))
    else $error("divider remainder out of range");

  // Phase moves only on the step state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_STEP) |=> $stable(phase_q))
    else $error("phase changed outside step");

  // Final sample of a request carries the run flag and frees the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && samp_last) |=> (state_q == ST_IDLE) && out_valid_q && out_o.data.last_of_run)
    else $error("run end not flagged");

  // An output waiting on the sink is never overwritten by a new sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> $stable(out_data_q))
    else $error("pending sample overwritten");

endmodule
